### rtl/q2e_pkg.sv
`default_nettype none

package q2e_pkg;

    // cordic depth and output angle precision
    localparam int CORDIC_STEPS = 16;
    localparam int ANGLE_BITS   = 16;

    // widths
    localparam int STEP_W     = 5;   // index into the arctangent list
    localparam int CW         = 34;  // cordic x, y and angle
    localparam int NW         = 32;  // normalized matrix numerators
    localparam int SQ_W       = 62;  // square root radicand and partial root
    localparam int SQRT_CELLS = 31;  // one root bit per cell
    localparam int SQRT_TOP_K = SQRT_CELLS - 1;

    // output rounding
    localparam int OUT_S1     = 32 - ANGLE_BITS;
    localparam int OUT_S1_HLF = (1 << OUT_S1) >> 1;
    localparam int OUT_R      = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
    localparam int OUT_R_HLF  = (1 << OUT_R) >> 1;
    localparam int OUT_L      = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } t_quat_in;

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
        logic               degenerate;
    } t_euler_out;

    // one atan2 lane of the cordic row
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 zero;
    } t_lane;

    typedef struct packed {
        t_lane [2:0] lane;
        logic        degen;
    } t_cordic;

    // square root partial state
    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] res;
    } t_sqrt;

    // arctangent of 2^-i, pi = 2^31
    function automatic logic signed [CW-1:0] f_atan(input logic [STEP_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return $signed({{(CW-32){1'b0}}, v});
    endfunction

    // round the internal angle to a 16-bit binary angle
    function automatic logic [15:0] f_to_out(input logic signed [CW-1:0] a);
        logic signed [CW+1:0] q;
        q = (CW+2)'(a) + (CW+2)'(OUT_S1_HLF);
        q = q >>> OUT_S1;
        q = (q + (CW+2)'(OUT_R_HLF)) >>> OUT_R;
        q = q <<< OUT_L;
        return q[15:0];
    endfunction

endpackage

`default_nettype wire

### rtl/q2e_sqrt_cell.sv
`default_nettype none

module q2e_sqrt_cell (
    input  logic                   i_clk,
    input  logic [q2e_pkg::STEP_W-1:0] i_k,
    input  q2e_pkg::t_sqrt         i_data,
    output q2e_pkg::t_sqrt         o_data
);
    import q2e_pkg::*;

    logic [SQ_W-1:0] bit_val;
    logic [SQ_W-1:0] trial;
    t_sqrt           n_data;
    t_sqrt           r_data;

    // one restoring root digit: trial subtract of res + 4^k
    always_comb begin
        bit_val = SQ_W'(1) << {i_k, 1'b0};
        trial   = i_data.res + bit_val;
        if (i_data.rem >= trial) begin
            n_data.rem = i_data.rem - trial;
            n_data.res = (i_data.res >> 1) + bit_val;
        end else begin
            n_data.rem = i_data.rem;
            n_data.res = i_data.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

### rtl/q2e_cordic_cell.sv
`default_nettype none

module q2e_cordic_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [q2e_pkg::STEP_W-1:0] i_step,
    input  logic                   i_valid,
    input  q2e_pkg::t_cordic       i_data,
    output logic                   o_valid,
    output q2e_pkg::t_cordic       o_data
);
    import q2e_pkg::*;

    logic signed [CW-1:0] tab;
    t_cordic              n_data;
    t_cordic              r_data;
    logic                 r_valid;

    // one vectoring micro-rotation on each of the three lanes
    always_comb begin
        tab    = f_atan(i_step);
        n_data = i_data;
        for (int i = 0; i < 3; i++) begin
            if (!i_data.lane[i].y[CW-1]) begin
                n_data.lane[i].x = i_data.lane[i].x + (i_data.lane[i].y >>> i_step);
                n_data.lane[i].y = i_data.lane[i].y - (i_data.lane[i].x >>> i_step);
                n_data.lane[i].z = i_data.lane[i].z + tab;
            end else begin
                n_data.lane[i].x = i_data.lane[i].x - (i_data.lane[i].y >>> i_step);
                n_data.lane[i].y = i_data.lane[i].y + (i_data.lane[i].x >>> i_step);
                n_data.lane[i].z = i_data.lane[i].z - tab;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

### rtl/quaternion_to_euler.sv
// channel   direction  handshake             payload
// command   in         start, busy           i_quat  (w, x, y, z)
// result    out        o_valid (strobe)      o_euler (roll, pitch, yaw, degenerate)
//
// fully pipelined: one quaternion accepted every cycle, busy is always low
// a sample passes the input stages, the 31-cell square root row, the pre-rotation
// register, the cordic row of CORDIC_STEPS cells and the result register
// synchronous active-low reset clears only the valid pipeline
// the receiver cannot stall; each result is shown for one cycle
`default_nettype none

module quaternion_to_euler (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  q2e_pkg::t_quat_in     i_quat,
    output logic                  o_valid,
    output q2e_pkg::t_euler_out   o_euler
);
    import q2e_pkg::*;

    localparam int N11 = 0;
    localparam int N12 = 1;
    localparam int N13 = 2;
    localparam int N23 = 3;
    localparam int N33 = 4;
    localparam int LATENCY = 9 + SQRT_CELLS + CORDIC_STEPS;

    // one signed numerator, so that element selects keep their sign
    typedef logic signed [NW-1:0] t_num;

    typedef struct packed {
        t_num [4:0] n;
        logic       degen;
    } t_nset;

    // stage 1: products
    logic               r_v1;
    logic signed [31:0] r_ww, r_xx, r_yy, r_zz, r_xy, r_wz, r_xz, r_wy, r_yz, r_wx;
    logic               r_dg1;
    // stage 2: length and numerators
    logic               r_v2;
    logic [32:0]        r_s2;
    logic signed [CW-1:0] r_n2 [5];
    logic               r_dg2;
    // stage 3: leading one
    logic               r_v3;
    logic [32:0]        r_s3;
    logic [5:0]         r_p3;
    logic               r_pw3;
    logic signed [CW-1:0] r_n3 [5];
    logic               r_dg3;
    // stage 4: shift amounts
    logic               r_v4;
    logic [4:0]         r_l4;
    logic [1:0]         r_r4;
    logic signed [CW-1:0] r_n4 [5];
    logic               r_dg4;
    // stage 5: normalized numerators
    logic               r_v5;
    t_nset              r_ns5;
    // stage 6: squares for the pitch cosine
    logic               r_v6;
    t_nset              r_ns6;
    logic [SQ_W-1:0]    r_q23, r_q33;
    // stage 7: radicand
    logic               r_v7;
    t_nset              r_ns7;
    logic [SQ_W-1:0]    r_rad;

    logic [5:0]         n_p3;
    logic [32:0]        n_t4;
    logic [4:0]         n_l4;
    logic [1:0]         n_r4;
    logic signed [NW-1:0] n_sc5 [5];
    logic signed [63:0] n_m23, n_m33;

    // squares of the normalized roll terms
    always_comb begin
        n_m23 = 64'(r_ns5.n[N23]) * 64'(r_ns5.n[N23]);
        n_m33 = 64'(r_ns5.n[N33]) * 64'(r_ns5.n[N33]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    // stage 1: all products of the raw sample
    always_ff @(posedge i_clk) begin
        r_ww  <= i_quat.quat_w * i_quat.quat_w;
        r_xx  <= i_quat.quat_x * i_quat.quat_x;
        r_yy  <= i_quat.quat_y * i_quat.quat_y;
        r_zz  <= i_quat.quat_z * i_quat.quat_z;
        r_xy  <= i_quat.quat_x * i_quat.quat_y;
        r_wz  <= i_quat.quat_w * i_quat.quat_z;
        r_xz  <= i_quat.quat_x * i_quat.quat_z;
        r_wy  <= i_quat.quat_w * i_quat.quat_y;
        r_yz  <= i_quat.quat_y * i_quat.quat_z;
        r_wx  <= i_quat.quat_w * i_quat.quat_x;
        r_dg1 <= (i_quat == '0);
    end

    // stage 2: squared length and matrix numerators
    always_ff @(posedge i_clk) begin
        r_s2     <= 33'(unsigned'(r_ww)) + 33'(unsigned'(r_xx))
                  + 33'(unsigned'(r_yy)) + 33'(unsigned'(r_zz));
        r_n2[N11] <= CW'(r_ww) + CW'(r_xx) - CW'(r_yy) - CW'(r_zz);
        r_n2[N12] <= (CW'(r_xy) - CW'(r_wz)) <<< 1;
        r_n2[N13] <= (CW'(r_xz) + CW'(r_wy)) <<< 1;
        r_n2[N23] <= (CW'(r_yz) - CW'(r_wx)) <<< 1;
        r_n2[N33] <= CW'(r_ww) + CW'(r_zz) - CW'(r_xx) - CW'(r_yy);
        r_dg2    <= r_dg1;
    end

    // stage 3: leading one of the length
    always_comb begin
        n_p3 = '0;
        for (int b = 0; b < 33; b++) begin
            if (r_s2[b]) begin
                n_p3 = 6'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3  <= r_s2;
        r_p3  <= n_p3;
        r_pw3 <= ((r_s2 & (r_s2 - 33'd1)) == '0);
        r_n3  <= r_n2;
        r_dg3 <= r_dg2;
    end

    // stage 4: shift that brings the length into (2^29, 2^30]
    always_comb begin
        n_t4 = r_s3;
        n_l4 = '0;
        n_r4 = '0;
        if (r_p3 >= 6'd30) begin
            case (r_p3)
                6'd30:   n_t4 = r_s3;
                6'd31:   n_t4 = r_s3 >> 1;
                default: n_t4 = r_s3 >> 2;
            endcase
            if (n_t4 == (33'd1 << 30)) begin
                n_r4 = 2'(r_p3 - 6'd30);
            end else begin
                n_r4 = 2'(r_p3 - 6'd29);
            end
        end else begin
            if (r_pw3) begin
                n_l4 = 5'(6'd30 - r_p3);
            end else begin
                n_l4 = 5'(6'd29 - r_p3);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_l4  <= n_l4;
        r_r4  <= n_r4;
        r_n4  <= r_n3;
        r_dg4 <= r_dg3;
    end

    // stage 5: scale every numerator by the same power of two
    always_comb begin
        for (int i = 0; i < 5; i++) begin
            if (r_l4 != '0) begin
                n_sc5[i] = NW'(r_n4[i] <<< r_l4);
            end else begin
                n_sc5[i] = NW'(r_n4[i] >>> r_r4);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 5; i++) begin
            r_ns5.n[i] <= n_sc5[i];
        end
        r_ns5.degen <= r_dg4;
    end

    // stages 6 and 7: radicand n23^2 + n33^2
    always_ff @(posedge i_clk) begin
        r_ns6 <= r_ns5;
        r_q23 <= n_m23[SQ_W-1:0];
        r_q33 <= n_m33[SQ_W-1:0];
        r_ns7 <= r_ns6;
        r_rad <= r_q23 + r_q33;
    end

    // square root row, numerators travel alongside
    t_sqrt sq_data [SQRT_CELLS+1];
    logic  r_dv [SQRT_CELLS];
    t_nset r_dn [SQRT_CELLS];

    assign sq_data[0] = '{rem: r_rad, res: '0};

    for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
        q2e_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_k    (STEP_W'(SQRT_TOP_K - g)),
            .i_data (sq_data[g]),
            .o_data (sq_data[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SQRT_CELLS; i++) begin
                r_dv[i] <= 1'b0;
            end
        end else begin
            r_dv[0] <= r_v7;
            for (int i = 1; i < SQRT_CELLS; i++) begin
                r_dv[i] <= r_dv[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dn[0] <= r_ns7;
        for (int i = 1; i < SQRT_CELLS; i++) begin
            r_dn[i] <= r_dn[i-1];
        end
    end

    // pre-rotation into the right half plane
    t_nset            pr_ns;
    logic signed [CW-1:0] pr_x [3];
    logic signed [CW-1:0] pr_y [3];
    t_cordic          n_pre;
    t_cordic          r_pre;
    logic             r_pre_v;

    always_comb begin
        pr_ns   = r_dn[SQRT_CELLS-1];
        pr_x[0] = CW'(pr_ns.n[N33]);
        pr_y[0] = CW'(pr_ns.n[N23]);
        pr_x[1] = CW'(sq_data[SQRT_CELLS].res[NW-1:0]);
        pr_y[1] = -CW'(pr_ns.n[N13]);
        pr_x[2] = CW'(pr_ns.n[N11]);
        pr_y[2] = CW'(pr_ns.n[N12]);
        n_pre.degen = pr_ns.degen;
        for (int i = 0; i < 3; i++) begin
            n_pre.lane[i].zero = (pr_x[i] == '0) && (pr_y[i] == '0);
            if (pr_x[i][CW-1]) begin
                n_pre.lane[i].x = -pr_x[i];
                n_pre.lane[i].y = -pr_y[i];
                n_pre.lane[i].z = CW'(64'sd1 <<< 31);
            end else begin
                n_pre.lane[i].x = pr_x[i];
                n_pre.lane[i].y = pr_y[i];
                n_pre.lane[i].z = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_v <= 1'b0;
        end else begin
            r_pre_v <= r_dv[SQRT_CELLS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pre <= n_pre;
    end

    // cordic row: roll, pitch and yaw in parallel lanes
    t_cordic cd_data  [CORDIC_STEPS+1];
    logic    cd_valid [CORDIC_STEPS+1];

    assign cd_data[0]  = r_pre;
    assign cd_valid[0] = r_pre_v;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        q2e_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (STEP_W'(g)),
            .i_valid (cd_valid[g]),
            .i_data  (cd_data[g]),
            .o_valid (cd_valid[g+1]),
            .o_data  (cd_data[g+1])
        );
    end

    // output rounding and result register
    t_cordic    fin;
    logic [15:0] n_ang [3];
    t_euler_out r_out;
    logic       r_out_v;

    always_comb begin
        fin = cd_data[CORDIC_STEPS];
        for (int i = 0; i < 3; i++) begin
            if (fin.degen || fin.lane[i].zero) begin
                n_ang[i] = '0;
            end else begin
                n_ang[i] = f_to_out(fin.lane[i].z);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= cd_valid[CORDIC_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.roll_angle  <= n_ang[0];
        r_out.pitch_angle <= n_ang[1];
        r_out.yaw_angle   <= n_ang[2];
        r_out.degenerate  <= fin.degen;
    end

    assign busy    = 1'b0;
    assign o_valid = r_out_v;
    assign o_euler = r_out;

    // a result leaves exactly one pipeline depth after its transaction
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LATENCY o_valid)
        else $error("result strobe does not match accepted transaction");

    // zero-length sample gives zero angles
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_euler.degenerate |->
            o_euler.roll_angle == 0 && o_euler.pitch_angle == 0
            && o_euler.yaw_angle == 0)
        else $error("degenerate result with nonzero angle");

    // pitch stays within a quarter turn
    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_euler.pitch_angle >= -16'sd16384
            && o_euler.pitch_angle <= 16'sd16384)
        else $error("pitch outside half pi range");

endmodule

`default_nettype wire

### tb/quaternion_to_euler_checker.sv
`default_nettype none

module quaternion_to_euler_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  q2e_pkg::t_quat_in     i_quat,
    input  logic                  o_valid,
    input  q2e_pkg::t_euler_out   o_euler,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import q2e_pkg::*;

    localparam longint ATAN_LIST [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0
    };

    t_euler_out euler_queue [$];
    int         mismatch_count;

    // floor shift right
    function automatic longint floor_shr(longint v, int k);
        if (v >= 0) return v >>> k;
        return -(((-v) - 1) >>> k) - 1;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    // cordic vectoring angle, pi = 2^31
    function automatic longint vector_angle(longint y, longint x);
        longint ang, dx, dy;
        ang = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            ang = 64'sd1 << 31;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; ang += ATAN_LIST[i];
            end else begin
                x -= dx; y += dy; ang -= ATAN_LIST[i];
            end
        end
        return ang;
    endfunction

    function automatic logic [15:0] binary_angle(longint a);
        longint q;
        int s1, rr;
        s1 = 32 - ANGLE_BITS;
        q = floor_shr(a + ((64'sd1 << s1) >>> 1), s1);
        if (ANGLE_BITS >= 16) begin
            rr = ANGLE_BITS - 16;
            q = floor_shr(q + ((64'sd1 << rr) >>> 1), rr);
        end else begin
            q = q * (64'sd1 << (16 - ANGLE_BITS));
        end
        return q[15:0];
    endfunction

    function automatic longint norm_term(longint v, int l, int r);
        return (l != 0) ? v * (64'sd1 << l) : floor_shr(v, r);
    endfunction

    // expected euler angles of one quaternion
    function automatic t_euler_out predict_euler(t_quat_in q);
        t_euler_out e;
        longint w, x, y, z, ww, xx, yy, zz, n11, n12, n13, n23, n33, h;
        longint unsigned s;
        int l, r;
        w = q.quat_w; x = q.quat_x; y = q.quat_y; z = q.quat_z;
        ww = w * w; xx = x * x; yy = y * y; zz = z * z;
        s = ww + xx + yy + zz;
        e = '0;
        if (s == 0) begin
            e.degenerate = 1'b1;
            return e;
        end
        n11 = ww + xx - yy - zz;
        n12 = 2 * (x * y - w * z);
        n13 = 2 * (x * z + w * y);
        n23 = 2 * (y * z - w * x);
        n33 = ww + zz - xx - yy;
        l = 0; r = 0;
        while ((s >> r) > (64'd1 << 30)) r++;
        if (r == 0) while ((s << l) <= (64'd1 << 29)) l++;
        n11 = norm_term(n11, l, r);
        n12 = norm_term(n12, l, r);
        n13 = norm_term(n13, l, r);
        n23 = norm_term(n23, l, r);
        n33 = norm_term(n33, l, r);
        h = int_sqrt(longint'(n23 * n23) + longint'(n33 * n33));
        e.roll_angle  = binary_angle(vector_angle(n23, n33));
        e.pitch_angle = binary_angle(vector_angle(-n13, h));
        e.yaw_angle   = binary_angle(vector_angle(n12, n11));
        return e;
    endfunction

    // predict on command, compare on result strobe
    always @(posedge i_clk) begin
        t_euler_out exp_e;
        if (i_rst_n) begin
            if (start && !busy) euler_queue.push_back(predict_euler(i_quat));
            if (o_valid) begin
                o_result_count <= o_result_count + 1;
                if (euler_queue.size() == 0) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("unexpected result transaction %p", o_euler);
                end else begin
                    exp_e = euler_queue.pop_front();
                    if (exp_e.roll_angle !== o_euler.roll_angle ||
                        exp_e.pitch_angle !== o_euler.pitch_angle ||
                        exp_e.yaw_angle !== o_euler.yaw_angle ||
                        exp_e.degenerate !== o_euler.degenerate) begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= 10)
                            $display("mismatch exp r=%0d p=%0d y=%0d d=%0b got r=%0d p=%0d y=%0d d=%0b",
                                $signed(exp_e.roll_angle), $signed(exp_e.pitch_angle),
                                $signed(exp_e.yaw_angle), exp_e.degenerate,
                                $signed(o_euler.roll_angle), $signed(o_euler.pitch_angle),
                                $signed(o_euler.yaw_angle), o_euler.degenerate);
                    end
                end
            end
        end
        o_fail_count <= mismatch_count;
        o_pending    <= euler_queue.size();
    end

    initial begin
        mismatch_count = 0;
        o_result_count = 0;
    end

endmodule

`default_nettype wire

### tb/quaternion_to_euler_tb.sv
`default_nettype none

module quaternion_to_euler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import q2e_pkg::*;

    localparam int LATENCY = 9 + 31 + CORDIC_STEPS;
    localparam int RANDOM_ITEMS = 1630;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_quat_in   i_quat;
    logic       o_valid;
    t_euler_out o_euler;
    int         fail_count;
    int         pending;
    int         result_count;
    int         sent_count;

    quaternion_to_euler uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_quat  (i_quat),
        .o_valid (o_valid),
        .o_euler (o_euler)
    );

    quaternion_to_euler_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_quat         (i_quat),
        .o_valid        (o_valid),
        .o_euler        (o_euler),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // hard stop
    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

    // component value that favors extremes and small magnitudes
    function automatic logic [15:0] rand_component();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(0, 8)) - 4);
            3: return 16'($signed($urandom_range(0, 512)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    // send one command transaction, with an optional idle gap first
    task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                             logic [15:0] z, int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_quat <= '{quat_w: w, quat_x: x, quat_y: y, quat_z: z};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent_count++;
    endtask

    function automatic int draw_gap(bit burst);
        return burst ? 0 : $urandom_range(0, 10);
    endfunction

    initial begin
        int  waited;
        bit  burst;
        logic [15:0] a, b;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_quat     = '0;
        sent_count = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: degenerate, axes, extremes, gimbal lock
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
        send_quat(16'h7fff, 16'h0000, 16'h0000, 16'h0000, 0);
        send_quat(16'h8000, 16'h0000, 16'h0000, 16'h0000, 1);
        send_quat(16'h0000, 16'h7fff, 16'h0000, 16'h0000, 0);
        send_quat(16'h0000, 16'h0000, 16'h8000, 16'h0000, 2);
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h7fff, 0);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
        send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 3);
        send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 0);
        send_quat(16'h0001, 16'h0000, 16'h0000, 16'h0000, 0);
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'hffff, 0);
        send_quat(16'h0001, 16'h0000, 16'h0001, 16'h0000, 0);  // pitch lock
        send_quat(16'h4000, 16'h0000, 16'hc000, 16'h0000, 1);  // pitch lock other side
        send_quat(16'h2000, 16'h2000, 16'h2000, 16'h2000, 0);  // both lock terms
        send_quat(16'h2000, 16'he000, 16'h2000, 16'he000, 0);
        send_quat(16'h0000, 16'h0001, 16'h0000, 16'h0000, 0);  // roll of pi
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0001, 0);  // yaw of pi
        send_quat(16'h0001, 16'h0001, 16'h0001, 16'h0001, 0);
        send_quat(16'hffff, 16'h0001, 16'hffff, 16'h0001, 4);
        send_quat(16'h5a82, 16'h5a82, 16'h0000, 16'h0000, 0);

        // random part with bursts and random gaps
        burst = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) burst = $urandom_range(0, 2) == 0;
            if ($urandom_range(0, 15) == 0) begin
                // gimbal lock family: x*z + w*y = +-S/2
                a = rand_component();
                b = rand_component();
                if ($urandom_range(0, 1))
                    send_quat(a, b, a, b, draw_gap(burst));
                else
                    send_quat(a, b, -a, -b, draw_gap(burst));
            end else if ($urandom_range(0, 40) == 0) begin
                send_quat('0, '0, '0, '0, draw_gap(burst));
            end else begin
                send_quat(rand_component(), rand_component(), rand_component(),
                          rand_component(), draw_gap(burst));
            end
        end
        start <= 1'b0;

        // drain
        waited = 0;
        while (pending != 0 && waited < 20 * LATENCY) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY + 4) @(posedge i_clk);

        $display("sent %0d quaternions, checked %0d euler results", sent_count, result_count);
        $display("covered degenerate, axis, extreme and gimbal lock inputs with random gaps");
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
